FILE: hdl/text_console_writer_defines.svh
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Shared property forms for the port-level checker of the console.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define TCW_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("console check failed");

// Next-cycle implication, disabled while reset is high.
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("console check failed");

// Implication that is also watched across the reset release.
`define TCW_ASSERT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("console check failed");

`endif

FILE: hdl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console writer package
// Types, constants and the cell address function shared by the console.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

   localparam int SCREEN_COLS = 80;
   localparam int SCREEN_ROWS = 25;
   localparam int COL_W       = 7;
   localparam int ROW_W       = 5;
   localparam int CELL_W      = 16;
   localparam int SCREEN_DEPTH = SCREEN_COLS * SCREEN_ROWS;
   localparam int ADDR_W      = $clog2(SCREEN_DEPTH);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [COL_W-1:0] LAST_COL = COL_W'(SCREEN_COLS - 1);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_ROWS - 1);

   localparam logic [1:0] CMD_PUT   = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;
   localparam logic [1:0] CMD_CLEAR = 2'd3;

   localparam logic [7:0]        CH_NEWLINE   = 8'd10;
   localparam logic [7:0]        CH_BACKSPACE = 8'd8;
   localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;

   typedef struct packed {
      logic [1:0]        command;
      logic [7:0]        char_code;
      logic [7:0]        color;
      logic signed [7:0] pos_col;
      logic signed [7:0] pos_row;
   } req_beat_type;

   typedef struct packed {
      logic [COL_W-1:0] cursor_col;
      logic [ROW_W-1:0] cursor_row;
      logic [7:0]       read_char;
      logic [7:0]       read_color;
   } rsp_beat_type;

   typedef enum logic [2:0] {
      OP_PUT,
      OP_NEWLINE,
      OP_BACKSPACE,
      OP_WRITE,
      OP_READ,
      OP_SKIP,
      OP_CLEAR
   } op_kind_type;

   typedef struct packed {
      op_kind_type       kind;
      logic [CELL_W-1:0] cell_word;
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } queue_out_type;

   typedef enum logic [1:0] {
      ST_FILL,
      ST_IDLE,
      ST_READ
   } back_state_type;

   // Logical row is rotated by the ring offset onto a physical row.
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col,
                                                   input logic [ROW_W-1:0] top);
      logic [ROW_W:0]   sum;
      logic [ROW_W-1:0] phys;
      sum = {1'b0, row} + {1'b0, top};
      if (sum >= (ROW_W+1)'(SCREEN_ROWS)) begin
         sum = sum - (ROW_W+1)'(SCREEN_ROWS);
      end
      phys = sum[ROW_W-1:0];
      return ADDR_W'(phys) * ADDR_W'(SCREEN_COLS) + ADDR_W'(col);
   endfunction

endpackage

`default_nettype wire

FILE: hdl/text_console_writer.sv
// ----------------------------------------------------------------------------
// Text console writer
// Character-cell console of 80 by 25 cells with a cursor and ring scrolling.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake           Beat
//   req_     in         req_valid/req_stall  command, char_code, color, pos_col, pos_row
//   rsp_     out        rsp_valid/rsp_stall  cursor_col, cursor_row, read_char, read_color
//
// A command beat enters the queue on the edge it is accepted and is carried out
// by the back end once it is idle and its output register is free; a read
// answers from the registered read of the screen memory. A scroll blanks one
// row (80 cells) and a clear every cell (2000), both one cell at a time through
// the single write port of the screen memory.
// After reset the screen memory is blanked in a pass over all 2000 cells;
// req_stall is high for that whole pass.
// Input and output stall independently: the two-entry queue keeps accepting
// while a finished response waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire tcw_pkg::req_beat_type req_beat,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output tcw_pkg::rsp_beat_type      rsp_beat
);

   tcw_pkg::op_type        front_op;
   tcw_pkg::queue_out_type queue_head;
   logic                   queue_full;
   logic                   queue_push;
   logic                   queue_pop;
   logic                   init_busy;

   // The front end only classifies and holds no state; the cursor, ring offset and screen live in the back end.
   tcw_front u_front (
      .req_beat (req_beat),
      .op       (front_op)
   );

   // Nothing is taken while the post-reset blanking pass is running.
   assign req_stall  = queue_full || init_busy;
   assign queue_push = req_valid && !req_stall;

   tcw_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (queue_push),
      .push_op (front_op),
      .pop     (queue_pop),
      .head    (queue_head),
      .full    (queue_full)
   );

   // The back end pops only when its output register is free or emptying, so
   // reads, scrolls and clears always find the register empty when they finish.
   tcw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (queue_head),
      .pop       (queue_pop),
      .init_busy (init_busy),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_beat  (rsp_beat)
   );

endmodule

`default_nettype wire

FILE: hdl/tcw_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/tcw_front.sv
// ----------------------------------------------------------------------------
// Console front end
// Sorts an incoming beat into one of the operations the back end performs.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_front (
   input  wire tcw_pkg::req_beat_type req_beat,
   output tcw_pkg::op_type            op
);

   logic on_screen;

   // Positions are signed; a negative value or one past the edge is off the screen.
   assign on_screen = !req_beat.pos_col[7] && !req_beat.pos_row[7]
                   && (req_beat.pos_col < 8'(tcw_pkg::SCREEN_COLS))
                   && (req_beat.pos_row < 8'(tcw_pkg::SCREEN_ROWS));

   always_comb begin
      op.cell_word = {req_beat.color, req_beat.char_code};
      op.col  = req_beat.pos_col[tcw_pkg::COL_W-1:0];
      op.row  = req_beat.pos_row[tcw_pkg::ROW_W-1:0];
      op.kind = tcw_pkg::OP_SKIP;
      case (req_beat.command)
         tcw_pkg::CMD_PUT: begin
            if (req_beat.char_code == tcw_pkg::CH_NEWLINE) begin
               op.kind = tcw_pkg::OP_NEWLINE;
            end else if (req_beat.char_code == tcw_pkg::CH_BACKSPACE) begin
               op.kind = tcw_pkg::OP_BACKSPACE;
            end else begin
               op.kind = tcw_pkg::OP_PUT;
            end
         end
         tcw_pkg::CMD_WRITE: begin
            op.kind = on_screen ? tcw_pkg::OP_WRITE : tcw_pkg::OP_SKIP;
         end
         tcw_pkg::CMD_READ: begin
            op.kind = on_screen ? tcw_pkg::OP_READ : tcw_pkg::OP_SKIP;
         end
         tcw_pkg::CMD_CLEAR: begin
            op.kind = tcw_pkg::OP_CLEAR;
         end
         default: begin
            op.kind = tcw_pkg::OP_SKIP;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: hdl/tcw_queue.sv
// ----------------------------------------------------------------------------
// Console operation queue
// Short queue of decoded operations between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire tcw_pkg::op_type        push_op,
   input  wire logic                   pop,
   output tcw_pkg::queue_out_type      head,
   output logic                        full
);

   tcw_pkg::op_type                entry_ff [tcw_pkg::QUEUE_DEPTH];
   logic [tcw_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [tcw_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [tcw_pkg::QPTR_W:0]       count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (tcw_pkg::QPTR_W+1)'(push) - (tcw_pkg::QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.op    = entry_ff[rd_ptr_ff];
   assign full       = (count_ff == (tcw_pkg::QPTR_W+1)'(tcw_pkg::QUEUE_DEPTH));

endmodule

`default_nettype wire

FILE: hdl/tcw_back.sv
// ----------------------------------------------------------------------------
// Console back end
// Owns the screen memory, cursor and ring offset and carries out operations.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire tcw_pkg::queue_out_type head,
   output logic                        pop,
   output logic                        init_busy,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output tcw_pkg::rsp_beat_type       rsp_beat
);

   tcw_pkg::back_state_type       state_ff, state_in;
   logic [tcw_pkg::COL_W-1:0]     cursor_x_ff, cursor_x_in;
   logic [tcw_pkg::ROW_W-1:0]     cursor_y_ff, cursor_y_in;
   logic [tcw_pkg::ROW_W-1:0]     top_ff, top_in;
   logic [tcw_pkg::ADDR_W-1:0]    fill_addr_ff, fill_addr_in;
   logic [tcw_pkg::ADDR_W-1:0]    fill_last_ff, fill_last_in;
   logic                          fill_resp_ff, fill_resp_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   tcw_pkg::rsp_beat_type         rsp_beat_ff, rsp_beat_in;

   logic                          ram_wr_en;
   logic [tcw_pkg::ADDR_W-1:0]    ram_wr_addr;
   logic [tcw_pkg::CELL_W-1:0]    ram_wr_data;
   logic                          ram_rd_en;
   logic [tcw_pkg::ADDR_W-1:0]    ram_rd_addr;
   logic [tcw_pkg::CELL_W-1:0]    ram_rd_data;

   logic                          rsp_free;
   logic                          rsp_load;
   logic                          do_newline;
   logic [tcw_pkg::CELL_W-1:0]    rsp_cell;
   logic [tcw_pkg::ADDR_W-1:0]    row_base;

   tcw_ram #(
      .WIDTH (tcw_pkg::CELL_W),
      .DEPTH (tcw_pkg::SCREEN_DEPTH)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // The row that leaves the top on a scroll becomes the new bottom row.
   assign row_base = tcw_pkg::ADDR_W'(top_ff) * tcw_pkg::ADDR_W'(tcw_pkg::SCREEN_COLS);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cursor_x_in  = cursor_x_ff;
      cursor_y_in  = cursor_y_ff;
      top_in       = top_ff;
      fill_addr_in = fill_addr_ff;
      fill_last_in = fill_last_ff;
      fill_resp_in = fill_resp_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = fill_addr_ff;
      ram_wr_data  = tcw_pkg::BLANK_CELL;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = tcw_pkg::cell_addr(head.op.row, head.op.col, top_ff);
      pop          = 1'b0;
      rsp_load     = 1'b0;
      do_newline   = 1'b0;
      rsp_cell     = '0;

      case (state_ff)
         tcw_pkg::ST_IDLE: begin
            if (head.valid && rsp_free) begin
               pop = 1'b1;
               case (head.op.kind)
                  tcw_pkg::OP_PUT: begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = tcw_pkg::cell_addr(cursor_y_ff, cursor_x_ff, top_ff);
                     ram_wr_data = head.op.cell_word;
                     if (cursor_x_ff == tcw_pkg::LAST_COL) begin
                        do_newline = 1'b1;
                     end else begin
                        cursor_x_in = cursor_x_ff + 1'b1;
                        rsp_load    = 1'b1;
                     end
                  end
                  tcw_pkg::OP_NEWLINE: begin
                     do_newline = 1'b1;
                  end
                  tcw_pkg::OP_BACKSPACE: begin
                     if (cursor_x_ff != '0) begin
                        cursor_x_in = cursor_x_ff - 1'b1;
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = tcw_pkg::cell_addr(cursor_y_ff, cursor_x_in, top_ff);
                     end
                     rsp_load = 1'b1;
                  end
                  tcw_pkg::OP_WRITE: begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = tcw_pkg::cell_addr(head.op.row, head.op.col, top_ff);
                     ram_wr_data = head.op.cell_word;
                     rsp_load    = 1'b1;
                  end
                  tcw_pkg::OP_READ: begin
                     ram_rd_en = 1'b1;
                     state_in  = tcw_pkg::ST_READ;
                  end
                  tcw_pkg::OP_CLEAR: begin
                     cursor_x_in  = '0;
                     cursor_y_in  = '0;
                     top_in       = '0;
                     fill_addr_in = '0;
                     fill_last_in = tcw_pkg::ADDR_W'(tcw_pkg::SCREEN_DEPTH - 1);
                     fill_resp_in = 1'b1;
                     state_in     = tcw_pkg::ST_FILL;
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         tcw_pkg::ST_READ: begin
            rsp_cell = ram_rd_data;
            rsp_load = 1'b1;
            state_in = tcw_pkg::ST_IDLE;
         end
         tcw_pkg::ST_FILL: begin
            ram_wr_en    = 1'b1;
            fill_addr_in = fill_addr_ff + 1'b1;
            if (fill_addr_ff == fill_last_ff) begin
               state_in = tcw_pkg::ST_IDLE;
               rsp_load = fill_resp_ff;
            end
         end
         default: begin
            state_in = tcw_pkg::ST_IDLE;
         end
      endcase

      // Move to the next line, scrolling through the ring offset on the last row.
      if (do_newline) begin
         cursor_x_in = '0;
         if (cursor_y_ff == tcw_pkg::LAST_ROW) begin
            top_in       = (top_ff == tcw_pkg::LAST_ROW) ? '0 : top_ff + 1'b1;
            fill_addr_in = row_base;
            fill_last_in = row_base + tcw_pkg::ADDR_W'(tcw_pkg::SCREEN_COLS - 1);
            fill_resp_in = 1'b1;
            state_in     = tcw_pkg::ST_FILL;
         end else begin
            cursor_y_in = cursor_y_ff + 1'b1;
            rsp_load    = 1'b1;
         end
      end

      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
      rsp_beat_in  = rsp_beat_ff;
      if (rsp_load) begin
         rsp_beat_in.cursor_col = cursor_x_in;
         rsp_beat_in.cursor_row = cursor_y_in;
         rsp_beat_in.read_char  = rsp_cell[7:0];
         rsp_beat_in.read_color = rsp_cell[15:8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcw_pkg::ST_FILL;
         cursor_x_ff  <= '0;
         cursor_y_ff  <= '0;
         top_ff       <= '0;
         fill_addr_ff <= '0;
         fill_last_ff <= tcw_pkg::ADDR_W'(tcw_pkg::SCREEN_DEPTH - 1);
         fill_resp_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_x_ff  <= cursor_x_in;
         cursor_y_ff  <= cursor_y_in;
         top_ff       <= top_in;
         fill_addr_ff <= fill_addr_in;
         fill_last_ff <= fill_last_in;
         fill_resp_ff <= fill_resp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_beat_ff <= rsp_beat_in;
   end

   assign init_busy = (state_ff == tcw_pkg::ST_FILL) && !fill_resp_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

endmodule

`default_nettype wire

FILE: hdl/tcw_checker.sv
// ----------------------------------------------------------------------------
// Text console writer checker
// Port-level properties of the console, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_console_writer_defines.svh"

module tcw_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_stall,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire tcw_pkg::rsp_beat_type rsp_beat
);

   // A held response keeps its beat.
   `TCW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_beat))

   // The cursor never leaves the screen.
   `TCW_ASSERT_NOW(a_col_range, clock, reset, rsp_valid, rsp_beat.cursor_col < 7'(tcw_pkg::SCREEN_COLS))
   `TCW_ASSERT_NOW(a_row_range, clock, reset, rsp_valid, rsp_beat.cursor_row < 5'(tcw_pkg::SCREEN_ROWS))

   // Right after reset the blanking pass holds off input and nothing is answered.
   `TCW_ASSERT_ALWAYS(a_init_quiet, clock, $fell(reset), req_stall && !rsp_valid)

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_beat  (rsp_beat)
);

`default_nettype wire
